// ===== sv/suit_pkg.sv =====
// ----------------------------------------------------------------------------
// suit_pkg
// Types and codes shared by the sorted unique insert table and its cells.
// ----------------------------------------------------------------------------
package suit_pkg;

   typedef logic signed [31:0] value_type;

   localparam logic ACT_INSERT = 1'b0;
   localparam logic ACT_CLEAR  = 1'b1;

   typedef enum logic [1:0] {
      ST_INSERTED  = 2'd0,
      ST_DUPLICATE = 2'd1,
      ST_FULL      = 2'd2,
      ST_CLEARED   = 2'd3
   } status_type;

   typedef struct packed {
      logic      action;
      value_type value;
   } req_type;

   typedef struct packed {
      status_type status;
      logic [4:0] position;
      logic [4:0] count_after;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic commit;
   } cell_ctl_type;

endpackage

// ===== sv/sorted_unique_insert_table.sv =====
// ----------------------------------------------------------------------------
// sorted_unique_insert_table
// Ascending table of distinct signed 32-bit values built as a row of cells.
// ----------------------------------------------------------------------------
// In the accept cycle every cell compares its entry with the value and
// registers less-than and equal flags. Once the output register is free, the
// flags give the duplicate check and insert position, the cells shift in one
// step and the result is loaded into the output register. req_stall stays
// high from accept until that load, so a new item is taken only after the
// last one is done. A result may wait in the output register while the next
// item is accepted and compared. There is no clearing pass: count_ff alone
// marks which slots hold data.
module sorted_unique_insert_table #(
   parameter int TABLE_DEPTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  suit_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output suit_pkg::rsp_type rsp_data
);
   import suit_pkg::*;

   localparam int CW = $clog2(TABLE_DEPTH + 1);

   logic                   busy_ff;
   logic                   busy_in;
   logic                   action_ff;
   value_type              value_ff;
   logic [CW-1:0]          count_ff;
   logic [CW-1:0]          count_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   rsp_type                rsp_ff;
   rsp_type                rsp_in;

   logic                   accept;
   logic                   done;
   logic                   dup;
   logic                   full;
   logic [CW-1:0]          pos;
   cell_ctl_type           ctl;
   value_type              cell_value;
   logic [TABLE_DEPTH-1:0] occ;
   logic [TABLE_DEPTH-1:0] lt_vec;
   logic [TABLE_DEPTH:0]   lt_ext;
   logic [TABLE_DEPTH-1:0] eq_vec;
   value_type              entry_vec [TABLE_DEPTH];

   assign req_stall = busy_ff;
   assign accept    = req_valid && !busy_ff;
   assign done      = busy_ff && (!rsp_valid_ff || !rsp_stall);

   assign dup  = |eq_vec;
   assign full = (count_ff == CW'(TABLE_DEPTH));

   assign ctl.capture = accept;
   assign ctl.commit  = done && (action_ff == ACT_INSERT) && !dup && !full;
   assign cell_value  = busy_ff ? value_ff : req_data.value;

   genvar g;
   generate
      for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
         assign occ[g] = (CW'(g) < count_ff);
         if (g == 0) begin : g_base
            suit_cell u_cell (
               .clock      (clock),
               .ctl        (ctl),
               .value      (cell_value),
               .occupied   (occ[g]),
               .prev_entry (cell_value),
               .prev_lt    (1'b1),
               .entry      (entry_vec[g]),
               .lt         (lt_vec[g]),
               .eq         (eq_vec[g])
            );
         end else begin : g_link
            suit_cell u_cell (
               .clock      (clock),
               .ctl        (ctl),
               .value      (cell_value),
               .occupied   (occ[g]),
               .prev_entry (entry_vec[g-1]),
               .prev_lt    (lt_vec[g-1]),
               .entry      (entry_vec[g]),
               .lt         (lt_vec[g]),
               .eq         (eq_vec[g])
            );
         end
      end
   endgenerate

   // flags form a thermometer; position is the edge of it
   assign lt_ext = {1'b0, lt_vec};

   always_comb begin
      pos = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (lt_ext[i] && !lt_ext[i+1]) begin
            pos = pos | CW'(i + 1);
         end
      end
   end

   always_comb begin
      rsp_in   = rsp_ff;
      count_in = count_ff;
      if (action_ff == ACT_CLEAR) begin
         rsp_in.status      = ST_CLEARED;
         rsp_in.position    = '0;
         rsp_in.count_after = '0;
         count_in           = '0;
      end else if (dup) begin
         rsp_in.status      = ST_DUPLICATE;
         rsp_in.position    = 5'(pos);
         rsp_in.count_after = 5'(count_ff);
      end else if (full) begin
         rsp_in.status      = ST_FULL;
         rsp_in.position    = '0;
         rsp_in.count_after = 5'(count_ff);
      end else begin
         count_in           = count_ff + 1'b1;
         rsp_in.status      = ST_INSERTED;
         rsp_in.position    = 5'(pos);
         rsp_in.count_after = 5'(count_in);
      end
   end

   always_comb begin
      busy_in      = busy_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (done) begin
         busy_in      = 1'b0;
         rsp_valid_in = 1'b1;
      end
      if (accept) begin
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         if (done) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         action_ff <= req_data.action;
         value_ff  <= req_data.value;
      end
      if (done) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(TABLE_DEPTH))
      else $error("entry count above table depth");

   a_lt_thermo: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> ((lt_vec & (lt_vec + 1'b1)) == '0))
      else $error("less-than flags not a thermometer code");

   a_dup_keeps_count: assert property (@(posedge clock) disable iff (reset)
      (done && (action_ff == ACT_INSERT) && dup) |=> $stable(count_ff))
      else $error("duplicate changed entry count");

   a_commit_not_full: assert property (@(posedge clock) disable iff (reset)
      ctl.commit |-> (count_ff < CW'(TABLE_DEPTH)))
      else $error("shift into a full table");
`endif

endmodule

// ===== sv/suit_cell.sv =====
// ----------------------------------------------------------------------------
// suit_cell
// One slot of the table: compares its entry against the item value, then
// keeps its entry, takes the new value, or takes its lower neighbor's entry.
// ----------------------------------------------------------------------------
module suit_cell (
   input  logic                  clock,
   input  suit_pkg::cell_ctl_type ctl,
   input  suit_pkg::value_type    value,
   input  logic                  occupied,
   input  suit_pkg::value_type    prev_entry,
   input  logic                  prev_lt,
   output suit_pkg::value_type    entry,
   output logic                  lt,
   output logic                  eq
);
   import suit_pkg::*;

   value_type entry_ff;
   value_type entry_in;
   logic      lt_ff;
   logic      lt_in;
   logic      eq_ff;
   logic      eq_in;

   always_comb begin
      lt_in = occupied && (entry_ff < value);
      eq_in = occupied && (entry_ff == value);
   end

   // below the insert point: keep; at it: new value; above: shift up
   always_comb begin
      if (lt_ff) begin
         entry_in = entry_ff;
      end else if (prev_lt) begin
         entry_in = value;
      end else begin
         entry_in = prev_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         lt_ff <= lt_in;
         eq_ff <= eq_in;
      end
      if (ctl.commit) begin
         entry_ff <= entry_in;
      end
   end

   assign entry = entry_ff;
   assign lt    = lt_ff;
   assign eq    = eq_ff;

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sorted unique insert table.
// ----------------------------------------------------------------------------
// A directed run covers the value extremes, duplicates, a full table and
// clears. Random runs of inserts then follow, mixed with the odd clear. The
// values come from narrow ranges, from the extremes, from earlier values and
// from the full 32-bit space. A shadow copy of the table predicts every
// result. Both channels idle at random, with bursts that run without idling.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import suit_pkg::*;

   localparam int DEPTH      = 16;
   localparam int RAND_ITEMS = 1900;
   localparam int MAX_CYCLES = 400000;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b1;
   rsp_type rsp_data;

   req_type   pending[$];
   rsp_type   predicted[$];
   value_type stored[DEPTH];
   int        stored_count = 0;
   int        req_issued   = 0;
   int        req_accepted = 0;
   int        rsp_taken    = 0;
   int        cycles       = 0;
   bit        failed       = 1'b0;

   sorted_unique_insert_table #(
      .TABLE_DEPTH(DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   // shadow table: applies one item and returns its result
   function rsp_type table_apply(req_type item);
      rsp_type r;
      int      below;
      bit      hit;
      r     = '0;
      below = 0;
      hit   = 1'b0;
      if (item.action == ACT_CLEAR) begin
         stored_count = 0;
         r.status     = ST_CLEARED;
         return r;
      end
      for (int i = 0; i < stored_count; i++) begin
         if (stored[i] < item.value) begin
            below++;
         end else if (stored[i] == item.value) begin
            hit = 1'b1;
         end
      end
      r.count_after = 5'(stored_count);
      if (hit) begin
         r.status   = ST_DUPLICATE;
         r.position = 5'(below);
      end else if (stored_count >= DEPTH) begin
         r.status = ST_FULL;
      end else begin
         for (int i = stored_count; i > below; i--) begin
            stored[i] = stored[i - 1];
         end
         stored[below] = item.value;
         stored_count++;
         r.status      = ST_INSERTED;
         r.position    = 5'(below);
         r.count_after = 5'(stored_count);
      end
      return r;
   endfunction

   function req_type make_insert(value_type v);
      req_type item;
      item.action = ACT_INSERT;
      item.value  = v;
      return item;
   endfunction

   function req_type make_clear();
      req_type item;
      item.action = ACT_CLEAR;
      item.value  = value_type'($urandom);
      return item;
   endfunction

   // request side
   always @(negedge clock) begin : drive_req
      int req_wait;
      bit burst;
      if (reset) begin
         req_valid <= 1'b0;
         req_wait  = 0;
         burst     = 1'b0;
      end else if (req_accepted == req_issued) begin
         if (req_wait > 0) begin
            req_wait--;
            req_valid <= 1'b0;
         end else if (pending.size() > 0) begin
            req_data  <= pending.pop_front();
            req_valid <= 1'b1;
            req_issued++;
            if ($urandom_range(0, 39) == 0) begin
               burst = ~burst;
            end
            req_wait = burst ? 0 : $urandom_range(0, 8);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result side
   always @(negedge clock) begin : drive_rsp
      int rsp_seen;
      int rsp_hold;
      bit burst;
      if (reset) begin
         rsp_stall <= 1'b1;
         rsp_seen  = 0;
         rsp_hold  = 0;
         burst     = 1'b0;
      end else begin
         if (rsp_taken != rsp_seen) begin
            rsp_seen = rsp_taken;
            if ($urandom_range(0, 39) == 0) begin
               burst = ~burst;
            end
            rsp_hold = burst ? 0 : $urandom_range(0, 8);
         end
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // check results, then record newly accepted items
   always @(posedge clock) begin : observe
      rsp_type want;
      cycles++;
      if (cycles > MAX_CYCLES) begin
         $display("== FAIL ==");
         $finish;
      end else if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            rsp_taken++;
            if (predicted.size() == 0) begin
               $error("unexpected item: status %0d position %0d count_after %0d",
                      rsp_data.status, rsp_data.position, rsp_data.count_after);
               failed = 1'b1;
            end else begin
               want = predicted.pop_front();
               if (rsp_data.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_data.status);
                  failed = 1'b1;
               end
               if (rsp_data.position !== want.position) begin
                  $error("position: expected %0d, got %0d",
                         want.position, rsp_data.position);
                  failed = 1'b1;
               end
               if (rsp_data.count_after !== want.count_after) begin
                  $error("count_after: expected %0d, got %0d",
                         want.count_after, rsp_data.count_after);
                  failed = 1'b1;
               end
            end
         end
         if (req_valid && !req_stall) begin
            predicted.push_back(table_apply(req_data));
            req_accepted++;
         end
      end
   end

   initial begin : stimulus
      value_type seen[$];
      value_type v;
      int        pick;

      // directed: extremes, duplicates, full table, clears
      pending.push_back(make_insert(32'sd0));
      pending.push_back(make_insert(32'h7FFF_FFFF));
      pending.push_back(make_insert(32'h8000_0000));
      pending.push_back(make_insert(-32'sd1));
      pending.push_back(make_insert(32'sd1));
      pending.push_back(make_insert(32'h7FFF_FFFF));
      pending.push_back(make_insert(32'h8000_0000));
      for (int i = 2; i <= 12; i++) begin
         pending.push_back(make_insert((i % 2) ? value_type'(i * 7919) : value_type'(-i * 7919)));
      end
      pending.push_back(make_insert(32'sd5));
      pending.push_back(make_insert(32'sd0));
      pending.push_back(make_insert(32'h7FFF_FFFF));
      pending.push_back(make_clear());
      pending.push_back(make_clear());
      pending.push_back(make_insert(32'h8000_0000));

      for (int n = 0; n < RAND_ITEMS; n++) begin
         if ($urandom_range(0, 99) < 4) begin
            pending.push_back(make_clear());
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
               v = value_type'($urandom_range(0, 40)) - 32'sd20;
            end else if (pick < 60) begin
               v = value_type'($urandom);
            end else if (pick < 75) begin
               v = value_type'($urandom_range(0, 7));
               v = ($urandom_range(0, 1) == 1) ? 32'h7FFF_FFFF - v : 32'h8000_0000 + v;
            end else if (seen.size() > 0) begin
               v = seen[$urandom_range(0, seen.size() - 1)];
            end else begin
               v = value_type'($urandom);
            end
            seen.push_back(v);
            if (seen.size() > 32) begin
               void'(seen.pop_front());
            end
            pending.push_back(make_insert(v));
         end
      end

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (pending.size() > 0 || req_accepted != req_issued || predicted.size() > 0) begin
         @(posedge clock);
      end
      repeat (20) @(posedge clock);

      if (!failed) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== files.f =====
sv/suit_pkg.sv
sv/suit_cell.sv
sv/sorted_unique_insert_table.sv
test/testbench.sv
